### rtl/core/fjsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjsp_pkg
// Shared phase codes, event kinds and result beat type for the flat JSON
// string object parser.
// ----------------------------------------------------------------------------
package fjsp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned KindW  = 3;

  typedef logic [PhaseW-1:0] phase_t;

  localparam phase_t PhOpen     = 4'd0;
  localparam phase_t PhFirst    = 4'd1;
  localparam phase_t PhKeyStart = 4'd2;
  localparam phase_t PhKey      = 4'd3;
  localparam phase_t PhKeyEsc   = 4'd4;
  localparam phase_t PhColon    = 4'd5;
  localparam phase_t PhValStart = 4'd6;
  localparam phase_t PhVal      = 4'd7;
  localparam phase_t PhValEsc   = 4'd8;
  localparam phase_t PhAfter    = 4'd9;
  localparam phase_t PhDone     = 4'd10;
  localparam phase_t PhFailed   = 4'd11;

  typedef enum logic [KindW-1:0] {
    EvNone     = 3'd0,
    EvKeyByte  = 3'd1,
    EvValByte  = 3'd2,
    EvKeyEnd   = 3'd3,
    EvPairEnd  = 3'd4,
    EvComplete = 3'd5,
    EvFail     = 3'd6
  } event_kind_e;

  localparam logic [ByteW-1:0] ChOpenBrace  = 8'h7b;
  localparam logic [ByteW-1:0] ChCloseBrace = 8'h7d;
  localparam logic [ByteW-1:0] ChQuote      = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash  = 8'h5c;
  localparam logic [ByteW-1:0] ChColon      = 8'h3a;
  localparam logic [ByteW-1:0] ChComma      = 8'h2c;
  localparam logic [ByteW-1:0] ChSpace      = 8'h20;
  localparam logic [ByteW-1:0] ChWsLo       = 8'h09;
  localparam logic [ByteW-1:0] ChWsHi       = 8'h0d;
  localparam logic [ByteW-1:0] ChMaxCount   = 8'hff;
  localparam logic [ByteW-1:0] MaxPairsRst  = 8'd32;

  typedef struct packed {
    event_kind_e      kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] pairs;
  } result_t;

  function automatic logic [ByteW-1:0] unescape(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    case (c)
      8'h62:   r = 8'h08;  // b
      8'h66:   r = 8'h0c;  // f
      8'h6e:   r = 8'h0a;  // n
      8'h72:   r = 8'h0d;  // r
      8'h74:   r = 8'h09;  // t
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/flat_json_string_object_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_json_string_object_parser
// Byte-serial checker and decoder for a flat JSON object of string pairs.
// timing: a result beat is valid in the cycle after its text beat is taken
// throughput: one text beat per cycle while the result buffer is not full;
//   phase update is one combinational step, phase register to result buffer
// reset: phase returns to expecting the opening brace, pair count to zero,
//   max_pairs to 32, the result buffer empties
// ----------------------------------------------------------------------------
module flat_json_string_object_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,       // max_pairs
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,      // [7:0] text_byte
  input  logic       s_axis_tlast,      // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [15:0] m_axis_tdata,     // [7:0] decoded_byte, [15:8] pairs_seen
  output logic [2:0] m_axis_tuser       // [2:0] event_kind
);
  import fjsp_pkg::*;

  phase_t     phase_q, phase_d;
  logic [7:0] pair_count_q, pair_count_d;
  logic [7:0] max_pairs_q;
  logic       accept;
  result_t    step_res;
  result_t    out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  fjsp_step u_step (
    .phase_i      (phase_q),
    .pair_count_i (pair_count_q),
    .max_pairs_i  (max_pairs_q),
    .text_byte_i  (s_axis_tdata),
    .end_of_text_i(s_axis_tlast),
    .phase_o      (phase_d),
    .pair_count_o (pair_count_d),
    .result_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhOpen;
      pair_count_q <= '0;
      max_pairs_q  <= MaxPairsRst;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        pair_count_q <= pair_count_d;
      end
      if (cfg_we_i) begin
        max_pairs_q <= cfg_wdata_i;
      end
    end
  end

  fjsp_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(step_res),
    .ready_o    (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .pop_ready_i(m_axis_tready),
    .pop_data_o (out_res)
  );

  assign m_axis_tdata = {out_res.pairs, out_res.data};
  assign m_axis_tuser = out_res.kind;

endmodule

### rtl/core/fjsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjsp_step
// Next phase, pair count and result for one text byte.
// ----------------------------------------------------------------------------
module fjsp_step (
  input  fjsp_pkg::phase_t     phase_i,
  input  logic [7:0]           pair_count_i,
  input  logic [7:0]           max_pairs_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  output fjsp_pkg::phase_t     phase_o,
  output logic [7:0]           pair_count_o,
  output fjsp_pkg::result_t    result_o
);
  import fjsp_pkg::*;

  logic        is_ws;
  logic        closing;
  phase_t      ph;
  logic [7:0]  cnt;
  event_kind_e ev;
  logic [7:0]  data;

  assign is_ws   = (text_byte_i == ChSpace) ||
                   (text_byte_i >= ChWsLo && text_byte_i <= ChWsHi);
  assign closing = end_of_text_i || (text_byte_i == '0);

  always_comb begin
    ph   = phase_i;
    cnt  = pair_count_i;
    ev   = EvNone;
    data = '0;
    if (closing) begin
      if (phase_i != PhDone && phase_i != PhFailed && phase_i <= PhFailed) begin
        ev = EvFail;
      end
      ph  = PhOpen;
      cnt = '0;
    end else begin
      case (phase_i)
        PhOpen: begin
          if (text_byte_i == ChOpenBrace) begin
            ph = PhFirst;
          end else if (!is_ws) begin
            ph = PhFailed;
            ev = EvFail;
          end
        end
        PhFirst: begin
          if (text_byte_i == ChCloseBrace) begin
            ph = PhDone;
            ev = EvComplete;
          end else if (text_byte_i == ChQuote && max_pairs_i != '0) begin
            ph = PhKey;
          end else if (!is_ws) begin
            ph = PhFailed;
            ev = EvFail;
          end
        end
        PhKeyStart: begin
          if (text_byte_i == ChQuote) begin
            ph = PhKey;
          end else if (!is_ws) begin
            ph = PhFailed;
            ev = EvFail;
          end
        end
        PhKey: begin
          if (text_byte_i == ChQuote) begin
            ph = PhColon;
            ev = EvKeyEnd;
          end else if (text_byte_i == ChBackslash) begin
            ph = PhKeyEsc;
          end else begin
            ev   = EvKeyByte;
            data = text_byte_i;
          end
        end
        PhKeyEsc: begin
          ph   = PhKey;
          ev   = EvKeyByte;
          data = unescape(text_byte_i);
        end
        PhColon: begin
          if (text_byte_i == ChColon) begin
            ph = PhValStart;
          end else if (!is_ws) begin
            ph = PhFailed;
            ev = EvFail;
          end
        end
        PhValStart: begin
          if (text_byte_i == ChQuote) begin
            ph = PhVal;
          end else if (!is_ws) begin
            ph = PhFailed;
            ev = EvFail;
          end
        end
        PhVal: begin
          if (text_byte_i == ChQuote) begin
            ph = PhAfter;
            ev = EvPairEnd;
            if (pair_count_i != ChMaxCount) begin
              cnt = pair_count_i + 8'd1;
            end
          end else if (text_byte_i == ChBackslash) begin
            ph = PhValEsc;
          end else begin
            ev   = EvValByte;
            data = text_byte_i;
          end
        end
        PhValEsc: begin
          ph   = PhVal;
          ev   = EvValByte;
          data = unescape(text_byte_i);
        end
        PhAfter: begin
          if (text_byte_i == ChCloseBrace) begin
            ph = PhDone;
            ev = EvComplete;
          end else if (text_byte_i == ChComma) begin
            if (pair_count_i >= max_pairs_i) begin
              ph = PhFailed;
              ev = EvFail;
            end else begin
              ph = PhKeyStart;
            end
          end else if (!is_ws) begin
            ph = PhFailed;
            ev = EvFail;
          end
        end
        PhDone: begin
          ph = PhDone;
        end
        default: begin
          ph = PhFailed;
        end
      endcase
    end
  end

  assign phase_o        = ph;
  assign pair_count_o   = cnt;
  assign result_o.kind  = ev;
  assign result_o.data  = data;
  // on a closing byte the count reported is the one before the reset
  assign result_o.pairs = closing ? pair_count_i : cnt;

endmodule

### rtl/core/fjsp_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjsp_obuf
// Two-entry result buffer; the spare entry absorbs a beat while the
// downstream side stalls, so the upstream ready is decoded from the registered count alone.
// ----------------------------------------------------------------------------
module fjsp_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fjsp_pkg::result_t    push_data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 pop_ready_i,
  output fjsp_pkg::result_t    pop_data_o
);
  import fjsp_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign ready_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop        = valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != 2'd2)
    else $error("beat pushed into full result buffer");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("result buffer pointers disagree with count");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> count_q == $past(count_q) + 2'd1)
    else $error("result buffer lost a beat");

endmodule
